@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define RAR_ASSERT_SAME(label, clk, rst, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error("rar check failed");

// condition implies consequence in the next cycle
`define RAR_ASSERT_NEXT(label, clk, rst, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("rar check failed");

`endif

@@ hw/rtl/rar_pkg.sv @@
// shared types and constants for the rational arithmetic reduction block
package rar_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;
  localparam int NUM_WIDTH     = PROD_WIDTH + 1;
  localparam int DEN_WIDTH     = PROD_WIDTH;
  localparam int QUEUE_DEPTH   = 2;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [0:0] {
    ST_OK       = 1'b0,
    ST_ZERO_DEN = 1'b1
  } status_t;

  typedef struct packed {
    logic [1:0]                       kind;
    logic signed [OPERAND_WIDTH-1:0] first_num;
    logic signed [OPERAND_WIDTH-1:0] first_den;
    logic signed [OPERAND_WIDTH-1:0] second_num;
    logic signed [OPERAND_WIDTH-1:0] second_den;
  } req_t;

  typedef struct packed {
    logic signed [NUM_WIDTH-1:0] result_num;
    logic signed [DEN_WIDTH-1:0] result_den;
    logic                        status;
  } rsp_t;

  // unreduced fraction handed from front to back
  typedef struct packed {
    logic signed [NUM_WIDTH-1:0] n;
    logic signed [DEN_WIDTH-1:0] d;
  } frac_t;

  typedef struct packed {
    logic  valid;
    frac_t frac;
  } qpush_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_MUL,
    FR_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_GCD,
    BK_DIVN,
    BK_DIVD,
    BK_OUT
  } back_state_t;

endpackage

@@ hw/rtl/rational_arith_reduce_core.sv @@
// top level of the rational arithmetic reduction block
// usage:
//   request channel: req_valid / req_stall / req carries two signed fractions and
//   an operation (add, subtract, multiply, divide).
//   response channel: rsp_valid / rsp_stall / rsp carries the reduced numerator,
//   the reduced denominator (sign as computed) and a status bit.
//   a zero computed denominator gives status 1 and 0/0; a zero numerator gives 0/1.
// timing:
//   the front end forms the cross-products in FR_MUL and queues them from FR_PUSH.
//   the back end runs a binary gcd (one step per cycle) followed by two restoring
//   divisions, numerator then denominator, on a single shared divider.
//   the special cases (a zero numerator or denominator) skip the gcd and divisions;
//   throughput is one request per back-end pass, set by the gcd loop and the divider.
// reset: rst is synchronous; it empties the queue and drops rsp_valid.
// stalls: a stalled response holds in the output register while the back end
//   starts the next request; req_stall is high while the front end is in FR_MUL
//   and FR_PUSH for each request and stays high while the queue is full.
module rational_arith_reduce_core #(
  parameter int QUEUE_DEPTH = rar_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  rar_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output rar_pkg::rsp_t rsp
);

  rar_pkg::qpush_t push;
  rar_pkg::frac_t  head;
  logic            q_full, q_valid, q_pop;

  rar_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_full    (q_full),
    .push      (push)
  );

  rar_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (q_full),
    .valid (q_valid),
    .pop   (q_pop),
    .head  (head)
  );

  rar_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .head      (head),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

@@ hw/rtl/rar_front.sv @@
// front end: takes a request, forms the cross-products and pushes the raw fraction
module rar_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  rar_pkg::req_t   req,
  input  logic            q_full,
  output rar_pkg::qpush_t push
);

  rar_pkg::front_state_t state, state_next;
  rar_pkg::req_t         item;
  logic signed [rar_pkg::PROD_WIDTH-1:0] p0, p1, pd;
  logic signed [rar_pkg::OPERAND_WIDTH-1:0] m0b, m2b;
  logic signed [rar_pkg::NUM_WIDTH-1:0] n_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rar_pkg::FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_stall  = 1'b1;
    push.valid = 1'b0;
    case (state)
      rar_pkg::FR_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          state_next = rar_pkg::FR_MUL;
        end
      end
      rar_pkg::FR_MUL: begin
        state_next = rar_pkg::FR_PUSH;
      end
      rar_pkg::FR_PUSH: begin
        if (!q_full) begin
          push.valid = 1'b1;
          state_next = rar_pkg::FR_IDLE;
        end
      end
      default: begin
        state_next = rar_pkg::FR_IDLE;
      end
    endcase
  end

  // operand selection per operation
  always_comb begin
    m0b = item.second_den;
    m2b = item.second_den;
    case (rar_pkg::op_t'(item.kind))
      rar_pkg::OP_MUL: m0b = item.second_num;
      rar_pkg::OP_DIV: m2b = item.second_num;
      default: begin
        m0b = item.second_den;
        m2b = item.second_den;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == rar_pkg::FR_IDLE && req_valid) begin
      item <= req;
    end
    if (state == rar_pkg::FR_MUL) begin
      p0 <= rar_pkg::PROD_WIDTH'(item.first_num * m0b);
      p1 <= rar_pkg::PROD_WIDTH'(item.second_num * item.first_den);
      pd <= rar_pkg::PROD_WIDTH'(item.first_den * m2b);
    end
  end

  always_comb begin
    case (rar_pkg::op_t'(item.kind))
      rar_pkg::OP_ADD: n_sum = rar_pkg::NUM_WIDTH'(p0) + rar_pkg::NUM_WIDTH'(p1);
      rar_pkg::OP_SUB: n_sum = rar_pkg::NUM_WIDTH'(p0) - rar_pkg::NUM_WIDTH'(p1);
      default:         n_sum = rar_pkg::NUM_WIDTH'(p0);
    endcase
  end

  assign push.frac.n = n_sum;
  assign push.frac.d = pd;

endmodule

@@ hw/rtl/rar_queue.sv @@
// short fifo between front and back
module rar_queue #(
  parameter int DEPTH = rar_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  rar_pkg::qpush_t push,
  output logic            full,
  output logic            valid,
  input  logic            pop,
  output rar_pkg::frac_t  head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  rar_pkg::frac_t mem [DEPTH];
  logic [PW-1:0]  wptr, rptr;
  logic [PW:0]    count;

  assign full  = (count == (PW+1)'(DEPTH));
  assign valid = (count != '0);
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push.valid && !full) begin
      mem[wptr] <= push.frac;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push.valid && !full) begin
        wptr <= (wptr == PW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (pop && valid) begin
        rptr <= (rptr == PW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (PW+1)'(push.valid && !full) - (PW+1)'(pop && valid);
    end
  end

endmodule

@@ hw/rtl/rar_back.sv @@
// back end: binary gcd, two restoring divisions and the response register
module rar_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_pop,
  input  rar_pkg::frac_t head,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output rar_pkg::rsp_t  rsp
);

  localparam int W  = rar_pkg::DEN_WIDTH;
  localparam int CW = $clog2(W);

  rar_pkg::back_state_t state, state_next;
  logic [W-1:0]  a, b, g, mag_n, mag_d, quo, qn;
  logic [W:0]    rem, rem_sh;
  logic [CW-1:0] k, cnt;
  logic          neg_n, neg_d;
  logic          div_ge;
  logic [W-1:0]  quo_next;
  logic          rsp_load;
  rar_pkg::rsp_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rar_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    rsp_load   = 1'b0;
    case (state)
      rar_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (head.d == '0 || head.n == '0) begin
            state_next = rar_pkg::BK_OUT;
          end else begin
            state_next = rar_pkg::BK_GCD;
          end
        end
      end
      rar_pkg::BK_GCD: begin
        if (a == b) begin
          state_next = rar_pkg::BK_DIVN;
        end
      end
      rar_pkg::BK_DIVN: begin
        if (cnt == CW'(W-1)) begin
          state_next = rar_pkg::BK_DIVD;
        end
      end
      rar_pkg::BK_DIVD: begin
        if (cnt == CW'(W-1)) begin
          state_next = rar_pkg::BK_OUT;
        end
      end
      rar_pkg::BK_OUT: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = rar_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = rar_pkg::BK_IDLE;
      end
    endcase
  end

  // one restoring division step
  assign rem_sh   = {rem[W-1:0], quo[W-1]};
  assign div_ge   = (rem_sh >= {1'b0, g});
  assign quo_next = {quo[W-2:0], div_ge};

  always_ff @(posedge clk) begin
    case (state)
      rar_pkg::BK_IDLE: begin
        neg_n <= head.n[rar_pkg::NUM_WIDTH-1];
        neg_d <= head.d[W-1];
        mag_n <= W'(head.n[rar_pkg::NUM_WIDTH-1] ? -head.n : head.n);
        mag_d <= head.d[W-1] ? W'(-head.d) : W'(head.d);
        a     <= W'(head.n[rar_pkg::NUM_WIDTH-1] ? -head.n : head.n);
        b     <= head.d[W-1] ? W'(-head.d) : W'(head.d);
        k     <= '0;
        if (head.d == '0) begin
          res.result_num <= '0;
          res.result_den <= '0;
          res.status     <= rar_pkg::ST_ZERO_DEN;
        end else begin
          res.result_num <= '0;
          res.result_den <= W'(1);
          res.status     <= rar_pkg::ST_OK;
        end
      end
      rar_pkg::BK_GCD: begin
        if (a == b) begin
          g   <= W'(a << k);
          rem <= '0;
          quo <= mag_n;
          cnt <= '0;
        end else if (!a[0] && !b[0]) begin
          a <= a >> 1;
          b <= b >> 1;
          k <= k + 1'b1;
        end else if (!a[0]) begin
          a <= a >> 1;
        end else if (!b[0]) begin
          b <= b >> 1;
        end else if (a > b) begin
          a <= (a - b) >> 1;
        end else begin
          b <= (b - a) >> 1;
        end
      end
      rar_pkg::BK_DIVN, rar_pkg::BK_DIVD: begin
        if (cnt == CW'(W-1)) begin
          rem <= '0;
          cnt <= '0;
          if (state == rar_pkg::BK_DIVN) begin
            qn  <= quo_next;
            quo <= mag_d;
          end else begin
            res.result_num <= neg_n ? -{1'b0, qn} : {1'b0, qn};
            res.result_den <= neg_d ? -quo_next : quo_next;
            res.status     <= rar_pkg::ST_OK;
          end
        end else begin
          rem <= div_ge ? rem_sh - {1'b0, g} : rem_sh;
          quo <= quo_next;
          cnt <= cnt + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // response register frees the back end while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= res;
    end
  end

endmodule

@@ hw/rtl/rar_checker.sv @@
// port-level checks for the rational arithmetic reduction block
`include "assert_macros.svh"

module rar_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input rar_pkg::rsp_t rsp
);

  logic rsp_err, rsp_zero_num;

  assign rsp_err      = rsp_valid && rsp.status;
  assign rsp_zero_num = rsp_valid && !rsp.status && rsp.result_num == '0;

  `RAR_ASSERT_NEXT(a_req_busy, clk, rst, req_valid && !req_stall, req_stall)
  `RAR_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid)
  `RAR_ASSERT_NEXT(a_rsp_stable, clk, rst, rsp_valid && rsp_stall, $stable(rsp))
  `RAR_ASSERT_SAME(a_err_zero, clk, rst, rsp_err, rsp.result_num == '0 && rsp.result_den == '0)
  `RAR_ASSERT_SAME(a_zero_unit, clk, rst, rsp_zero_num, rsp.result_den == 32'sd1)

endmodule

bind rational_arith_reduce_core rar_checker u_rar_checker (.*);

@@ tb/tb.sv @@
// testbench for the rational arithmetic reduction core: scoreboard, drivers and stimulus
module tb;

  // predicted reductions, oldest first, compared against each response
  class fraction_scoreboard;
    rar_pkg::rsp_t pending[$];
    int   errors;
    int   checked;

    function void note_request(rar_pkg::req_t r);
      longint an, ad, bn, bd, n, d, g, x, y, t;
      rar_pkg::rsp_t e;
      an = longint'(r.first_num);
      ad = longint'(r.first_den);
      bn = longint'(r.second_num);
      bd = longint'(r.second_den);
      case (rar_pkg::op_t'(r.kind))
        rar_pkg::OP_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
        rar_pkg::OP_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
        rar_pkg::OP_MUL: begin n = an * bn; d = ad * bd; end
        default: begin n = an * bd; d = ad * bn; end
      endcase
      e = '0;
      if (d == 0) begin
        e.status = rar_pkg::ST_ZERO_DEN;
      end else if (n == 0) begin
        e.result_den = rar_pkg::DEN_WIDTH'(1);
        e.status = rar_pkg::ST_OK;
      end else begin
        x = (n < 0) ? -n : n;
        y = (d < 0) ? -d : d;
        while (y != 0) begin
          t = x % y;
          x = y;
          y = t;
        end
        g = x;
        e.result_num = rar_pkg::NUM_WIDTH'(n / g);
        e.result_den = rar_pkg::DEN_WIDTH'(d / g);
        e.status = rar_pkg::ST_OK;
      end
      pending.push_back(e);
    endfunction

    function void check_response(rar_pkg::rsp_t got);
      rar_pkg::rsp_t e;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected response %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.result_num !== e.result_num) begin
        $display("%0t: result_num expected %0d actual %0d", $time, e.result_num,
                 got.result_num);
        errors++;
      end
      if (got.result_den !== e.result_den) begin
        $display("%0t: result_den expected %0d actual %0d", $time, e.result_den,
                 got.result_den);
        errors++;
      end
      if (got.status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
        errors++;
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 1500000;

  logic clk, rst;
  logic req_valid, req_stall, rsp_valid, rsp_stall;
  rar_pkg::req_t req;
  rar_pkg::rsp_t rsp;
  int   send_idle_pct, recv_idle_pct;
  int   requests_sent;
  longint cycles;
  fraction_scoreboard board;

  rational_arith_reduce_core dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // sample both channels at the rising edge
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (req_valid && !req_stall) board.note_request(req);
      if (rsp_valid && !rsp_stall) board.check_response(rsp);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d responses outstanding", board.pending.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver stalls at random
  always @(negedge clk) begin
    if (rst) rsp_stall <= 1'b0;
    else rsp_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  function automatic logic [15:0] pick_operand();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 2)) - 16'd1;
      3: return 16'($urandom_range(0, 40)) - 16'd20;
      default: return 16'($urandom);
    endcase
  endfunction

  // valid stays high into the next request unless the sender idles
  task automatic send_request(logic [1:0] k, logic [15:0] an, logic [15:0] ad,
                              logic [15:0] bn, logic [15:0] bd);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= '{kind: k, first_num: an, first_den: ad, second_num: bn, second_den: bd};
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
    requests_sent++;
  endtask

  task automatic random_requests(int count);
    for (int i = 0; i < count; i++)
      send_request(2'($urandom), pick_operand(), pick_operand(), pick_operand(),
                   pick_operand());
  endtask

  initial begin
    board = new();
    cycles = 0;
    requests_sent = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed corners: every operation, extremes, zero cases
    send_request(rar_pkg::OP_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
    send_request(rar_pkg::OP_SUB, 16'd1, 16'd2, 16'd1, 16'd2);
    send_request(rar_pkg::OP_MUL, 16'd6, 16'd4, 16'd2, 16'd3);
    send_request(rar_pkg::OP_DIV, 16'd3, 16'd4, 16'd9, 16'd8);
    send_request(rar_pkg::OP_ADD, 16'd5, 16'd0, 16'd1, 16'd1);
    send_request(rar_pkg::OP_DIV, 16'd5, 16'd3, 16'd0, 16'd7);
    send_request(rar_pkg::OP_MUL, 16'd0, 16'd0, 16'd0, 16'd0);
    send_request(rar_pkg::OP_MUL, 16'd0, 16'd5, 16'd3, 16'd7);
    send_request(rar_pkg::OP_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_request(rar_pkg::OP_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_request(rar_pkg::OP_ADD, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    send_request(rar_pkg::OP_MUL, 16'h8000, 16'h7fff, 16'h8000, 16'hffff);
    send_request(rar_pkg::OP_DIV, 16'h7fff, 16'hffff, 16'h8000, 16'h7fff);
    send_request(rar_pkg::OP_DIV, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_request(rar_pkg::OP_SUB, 16'hffff, 16'd3, 16'd2, 16'hfffd);
    send_request(rar_pkg::OP_ADD, 16'hffff, 16'hffff, 16'h7fff, 16'h8000);

    send_idle_pct = 10;
    recv_idle_pct = 53;
    random_requests(400);
    send_idle_pct = 53;
    recv_idle_pct = 10;
    random_requests(400);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_requests(400);
    req_valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d requests covering all four operations, zero and extreme operands",
             requests_sent);
    $display("checked %0d responses under sender and receiver stalls", board.checked);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/rar_pkg.sv
hw/rtl/rar_front.sv
hw/rtl/rar_queue.sv
hw/rtl/rar_back.sv
hw/rtl/rational_arith_reduce_core.sv
hw/rtl/rar_checker.sv
tb/tb.sv
